// ----- design/pimap_pkg.sv -----
`default_nettype none
package pimap_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS = 16;
   localparam int COEF_BITS = 32;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [CSR_IDX_BITS-1:0] CSR_M00_M01 = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_M02_M10 = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_M11_M12 = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_M20_M21 = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_M22 = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SRC_SIZE = 3'd5;

   localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << FRAC_BITS;

   // control that travels along the divider
   typedef struct packed {
      logic valid;
      logic ok;
   } ctl_type;

endpackage
`default_nettype wire

// ----- design/pimap_row.sv -----
`default_nettype none
// one homogeneous row: a*x2 + b*y2 + 2*c, products then sum
module pimap_row import pimap_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic signed [COEF_BITS-1:0]          coef_a,
   input  wire logic signed [COEF_BITS-1:0]          coef_b,
   input  wire logic signed [COEF_BITS-1:0]          coef_c,
   input  wire logic signed [COORD_BITS+1:0]         x2,
   input  wire logic signed [COORD_BITS+1:0]         y2,
   output logic signed [COEF_BITS+COORD_BITS+3:0]    sum_ff
);
   localparam int PW = COEF_BITS + COORD_BITS + 2;
   localparam int SW = PW + 2;

   logic signed [PW-1:0] pa_ff, pb_ff, pc_ff;
   logic signed [PW-1:0] pa_in, pb_in, pc_in;
   logic signed [SW-1:0] sum_in;

   assign pa_in = PW'(coef_a) * PW'(x2);
   assign pb_in = PW'(coef_b) * PW'(y2);
   assign pc_in = PW'(coef_c) <<< 1;
   assign sum_in = SW'(pa_ff) + SW'(pb_ff) + SW'(pc_ff);

   always_ff @(posedge clock) begin
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      pc_ff <= pc_in;
      sum_ff <= sum_in;
   end
endmodule
`default_nettype wire

// ----- design/pimap_div_step.sv -----
`default_nettype none
// one restoring step for both quotients, shared divisor
module pimap_div_step import pimap_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int SHIFT = 0
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire ctl_type                                 ctl_i,
   input  wire logic [COEF_BITS+2*COORD_BITS+3:0]       rem_u_i,
   input  wire logic [COEF_BITS+2*COORD_BITS+3:0]       rem_v_i,
   input  wire logic [COORD_BITS-1:0]                   q_u_i,
   input  wire logic [COORD_BITS-1:0]                   q_v_i,
   input  wire logic [COEF_BITS+COORD_BITS+3:0]         den_i,
   output ctl_type                                      ctl_ff,
   output logic [COEF_BITS+2*COORD_BITS+3:0]            rem_u_ff,
   output logic [COEF_BITS+2*COORD_BITS+3:0]            rem_v_ff,
   output logic [COORD_BITS-1:0]                        q_u_ff,
   output logic [COORD_BITS-1:0]                        q_v_ff,
   output logic [COEF_BITS+COORD_BITS+3:0]              den_ff
);
   localparam int SW = COEF_BITS + COORD_BITS + 4;
   localparam int DW = SW + COORD_BITS;

   logic [DW-1:0] dsh;
   logic          ge_u, ge_v;
   logic [DW-1:0] rem_u_in, rem_v_in;
   logic [COORD_BITS-1:0] q_u_in, q_v_in;

   assign dsh = DW'(den_i) << SHIFT;
   assign ge_u = rem_u_i >= dsh;
   assign ge_v = rem_v_i >= dsh;
   assign rem_u_in = ge_u ? rem_u_i - dsh : rem_u_i;
   assign rem_v_in = ge_v ? rem_v_i - dsh : rem_v_i;
   assign q_u_in = {q_u_i[COORD_BITS-2:0], ge_u};
   assign q_v_in = {q_v_i[COORD_BITS-2:0], ge_v};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
      rem_u_ff <= rem_u_in;
      rem_v_ff <= rem_v_in;
      q_u_ff <= q_u_in;
      q_v_ff <= q_v_in;
      den_ff <= den_i;
   end
endmodule
`default_nettype wire

// ----- design/projective_inverse_warp_map.sv -----
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// The depth is set by the restoring divider, one quotient bit per stage.
// Reset: synchronous, active high; clears pipeline valids and loads the
// identity matrix with a zero source size.
`default_nettype none
module projective_inverse_warp_map import pimap_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [COORD_BITS-1:0]      req_out_col,
   input  wire logic [COORD_BITS-1:0]      req_out_row,
   output logic                            rsp_valid,
   output logic [COORD_BITS-1:0]           rsp_src_col,
   output logic [COORD_BITS-1:0]           rsp_src_row,
   output logic                            rsp_inside_res,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]   csr_wdata
);
   localparam int SW = COEF_BITS + COORD_BITS + 4;  // homogeneous sum width
   localparam int DW = SW + COORD_BITS;             // remainder width
   localparam int LAT = COORD_BITS + 4;

   // ---------------- configuration registers ----------------
   logic [CSR_DATA_BITS-1:0] m00_m01_ff, m02_m10_ff, m11_m12_ff, m20_m21_ff;
   logic [COEF_BITS-1:0]     m22_ff, size_ff;

   assign csr_ready = 1'b1;
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         m00_m01_ff <= {COEF_ONE, COEF_BITS'(0)};
         m02_m10_ff <= '0;
         m11_m12_ff <= {COEF_ONE, COEF_BITS'(0)};
         m20_m21_ff <= '0;
         m22_ff <= COEF_ONE;
         size_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_M00_M01: m00_m01_ff <= csr_wdata;
            CSR_M02_M10: m02_m10_ff <= csr_wdata;
            CSR_M11_M12: m11_m12_ff <= csr_wdata;
            CSR_M20_M21: m20_m21_ff <= csr_wdata;
            CSR_M22: m22_ff <= csr_wdata[COEF_BITS-1:0];
            CSR_SRC_SIZE: size_ff <= csr_wdata[COEF_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- stages 1-2: the three rows ----------------
   // pixel center doubled: 2*col + 1, one fraction bit
   logic signed [COORD_BITS+1:0] x2, y2;
   logic signed [SW-1:0] un, vn, wn;
   logic acc;
   logic v1_ff, v2_ff;

   assign acc = start && !busy;
   assign x2 = {1'b0, req_out_col, 1'b1};
   assign y2 = {1'b0, req_out_row, 1'b1};

   pimap_row #(.COORD_BITS(COORD_BITS)) u_row_u (
      .clock(clock),
      .coef_a(m00_m01_ff[2*COEF_BITS-1:COEF_BITS]),
      .coef_b(m00_m01_ff[COEF_BITS-1:0]),
      .coef_c(m02_m10_ff[2*COEF_BITS-1:COEF_BITS]),
      .x2(x2), .y2(y2), .sum_ff(un)
   );
   pimap_row #(.COORD_BITS(COORD_BITS)) u_row_v (
      .clock(clock),
      .coef_a(m02_m10_ff[COEF_BITS-1:0]),
      .coef_b(m11_m12_ff[2*COEF_BITS-1:COEF_BITS]),
      .coef_c(m11_m12_ff[COEF_BITS-1:0]),
      .x2(x2), .y2(y2), .sum_ff(vn)
   );
   pimap_row #(.COORD_BITS(COORD_BITS)) u_row_w (
      .clock(clock),
      .coef_a(m20_m21_ff[2*COEF_BITS-1:COEF_BITS]),
      .coef_b(m20_m21_ff[COEF_BITS-1:0]),
      .coef_c(m22_ff),
      .x2(x2), .y2(y2), .sum_ff(wn)
   );

   // ---------------- stage 3: range screen ----------------
   // w must be positive; u, v must lie in [0, w << COORD_BITS) so the
   // quotient fits the divider. Anything else is outside.
   logic          wpos, ok_in;
   logic [DW-1:0] wlim;
   ctl_type       ctl3_ff;
   logic [DW-1:0] rem_u3_ff, rem_v3_ff;
   logic [SW-1:0] den3_ff;

   assign wpos = !wn[SW-1] && (wn != '0);
   assign wlim = DW'(unsigned'(wn)) << COORD_BITS;
   assign ok_in = wpos && !un[SW-1] && !vn[SW-1]
                  && (DW'(unsigned'(un)) < wlim) && (DW'(unsigned'(vn)) < wlim);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         ctl3_ff <= '0;
      end else begin
         v1_ff <= acc;
         v2_ff <= v1_ff;
         ctl3_ff <= '{valid: v2_ff, ok: ok_in};
      end
      rem_u3_ff <= DW'(unsigned'(un));
      rem_v3_ff <= DW'(unsigned'(vn));
      den3_ff <= unsigned'(wn);
   end

   // ---------------- divider: one quotient bit per stage ----------------
   ctl_type               ctl_s [0:COORD_BITS];
   logic [DW-1:0]         rem_u_s [0:COORD_BITS];
   logic [DW-1:0]         rem_v_s [0:COORD_BITS];
   logic [COORD_BITS-1:0] q_u_s [0:COORD_BITS];
   logic [COORD_BITS-1:0] q_v_s [0:COORD_BITS];
   logic [SW-1:0]         den_s [0:COORD_BITS];

   assign ctl_s[0] = ctl3_ff;
   assign rem_u_s[0] = rem_u3_ff;
   assign rem_v_s[0] = rem_v3_ff;
   assign q_u_s[0] = '0;
   assign q_v_s[0] = '0;
   assign den_s[0] = den3_ff;

   for (genvar k = 0; k < COORD_BITS; k++) begin : g_div
      pimap_div_step #(.COORD_BITS(COORD_BITS), .SHIFT(COORD_BITS-1-k)) u_step (
         .clock(clock), .reset(reset),
         .ctl_i(ctl_s[k]), .rem_u_i(rem_u_s[k]), .rem_v_i(rem_v_s[k]),
         .q_u_i(q_u_s[k]), .q_v_i(q_v_s[k]), .den_i(den_s[k]),
         .ctl_ff(ctl_s[k+1]), .rem_u_ff(rem_u_s[k+1]), .rem_v_ff(rem_v_s[k+1]),
         .q_u_ff(q_u_s[k+1]), .q_v_ff(q_v_s[k+1]), .den_ff(den_s[k+1])
      );
   end

   // ---------------- output stage: image bounds ----------------
   logic                  inside_in;
   logic                  rsp_valid_ff, inside_ff;
   logic [COORD_BITS-1:0] col_ff, row_ff;

   assign inside_in = ctl_s[COORD_BITS].ok
      && (16'(q_u_s[COORD_BITS]) < size_ff[31:16])
      && (16'(q_v_s[COORD_BITS]) < size_ff[15:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_s[COORD_BITS].valid;
      end
      inside_ff <= inside_in;
      col_ff <= inside_in ? q_u_s[COORD_BITS] : '0;
      row_ff <= inside_in ? q_v_s[COORD_BITS] : '0;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_inside_res = inside_ff;
   assign rsp_src_col = col_ff;
   assign rsp_src_row = row_ff;

   // ---------------- checks ----------------
   a_lat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(acc, LAT))
      else $error("result without matching item");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside_res |-> rsp_src_col == '0 && rsp_src_row == '0)
      else $error("outside result carries coordinates");
   a_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_res |-> 16'(rsp_src_col) < size_ff[31:16]
                                      && 16'(rsp_src_row) < size_ff[15:0])
      else $error("inside result beyond source size");
endmodule
`default_nettype wire
